>>> src/cft_pkg.sv
`default_nettype none

package cft_pkg;

   // Widths fixed by the transaction fields.
   localparam int ChanW    = 64;
   localparam int CircInW  = 16;
   localparam int CellW    = 16;
   localparam int CircTotW = 7;
   localparam int CellTotW = 22;
   localparam int StatusW  = 2;

   // Home slot hash and its reduction to a slot index.
   localparam int HashW            = 32;
   localparam int HashCircShift    = 8;
   localparam int HashBitsPerCycle = 8;
   localparam int HashSteps        = HashW / HashBitsPerCycle;

   // Defaults for the top-level parameters.
   localparam int TableEntriesDef = 64;
   localparam int CircIdBitsDef   = 16;

   typedef enum logic {
      FUNC_ATTACH = 1'b0,
      FUNC_QUERY  = 1'b1
   } func_type;

   typedef enum logic {
      DIR_OUT = 1'b0,
      DIR_IN  = 1'b1
   } dir_type;

   typedef enum logic [StatusW-1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_MISMATCH = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_PROBE,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

>>> src/circuit_flow_table_with_counters.sv
`default_nettype none
// S_IDLE takes the transaction, S_HASH reduces the hash to a home slot a byte at a time,
// S_PROBE probes one slot per cycle (one to TABLE_ENTRIES), S_DONE presents the result.
// A query that misses on the out-side key and falls back repeats the hash and probe phases.
// The block holds one transaction at a time; req_stall is high outside S_IDLE.
// Reset: the totals are cleared at once, then a clearing pass over all TABLE_ENTRIES slots
// empties the table memory; req_stall stays high until it completes.

module circuit_flow_table_with_counters #(
   parameter int TABLE_ENTRIES = cft_pkg::TableEntriesDef,
   parameter int CIRC_ID_BITS  = cft_pkg::CircIdBitsDef
) (
   input  wire logic                          clock,
   input  wire logic                          reset,

   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_func,
   input  wire logic [cft_pkg::ChanW-1:0]     req_chan_id,
   input  wire logic [cft_pkg::CircInW-1:0]   req_circ_id,
   input  wire logic                          req_direction,
   input  wire logic [cft_pkg::CellW-1:0]     req_cell_count,
   input  wire logic                          req_alt_valid,
   input  wire logic [cft_pkg::ChanW-1:0]     req_alt_chan_id,
   input  wire logic [cft_pkg::CircInW-1:0]   req_alt_circ_id,

   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_found,
   output logic                               rsp_found_direction,
   output logic [cft_pkg::StatusW-1:0]        rsp_status,
   output logic [cft_pkg::CircTotW-1:0]       rsp_total_circuits,
   output logic [cft_pkg::CircTotW-1:0]       rsp_loaded_circuits,
   output logic [cft_pkg::CellTotW-1:0]       rsp_total_cells
);

   import cft_pkg::*;

   localparam int IdxW    = $clog2(TABLE_ENTRIES);
   localparam int RemW    = IdxW + 1;
   localparam int CntW    = $clog2(TABLE_ENTRIES + 1);
   localparam int CircW   = (CIRC_ID_BITS < CircInW) ? CIRC_ID_BITS : CircInW;
   localparam int EntryW  = 2 + CellW + CircW + ChanW;
   localparam int StepW   = (HashSteps > 1) ? $clog2(HashSteps) : 1;

   function automatic logic [HashW-1:0] key_hash(input logic [ChanW-1:0] chan,
                                                 input logic [CircW-1:0] circ);
      logic [HashW-1:0] circ_part;
      circ_part = HashW'(circ) << HashCircShift;
      return circ_part ^ chan[ChanW-1:HashW] ^ chan[HashW-1:0];
   endfunction

   // Control registers.
   state_type            state_ff, state_in;
   logic [IdxW-1:0]      idx_ff, idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CircTotW-1:0]  circ_total_ff, circ_total_in;
   logic [CircTotW-1:0]  active_total_ff, active_total_in;
   logic [CellTotW-1:0]  cell_total_ff, cell_total_in;

   // Transaction and working registers.
   func_type             func_ff, func_in;
   logic [ChanW-1:0]     chan_ff, chan_in;
   logic [CircW-1:0]     circ_ff, circ_in;
   logic                 dir_ff, dir_in;
   logic [CellW-1:0]     cells_ff, cells_in;
   logic                 alt_valid_ff, alt_valid_in;
   logic [ChanW-1:0]     alt_chan_ff, alt_chan_in;
   logic [CircW-1:0]     alt_circ_ff, alt_circ_in;
   logic                 alt_sel_ff, alt_sel_in;
   logic [HashW-1:0]     hash_ff, hash_in;
   logic [StepW-1:0]     step_ff, step_in;
   logic [CntW-1:0]      cnt_ff, cnt_in;
   logic                 found_ff, found_in;
   logic                 fdir_ff, fdir_in;
   status_type           status_ff, status_in;

   // Output registers.
   logic                 rsp_found_ff, rsp_found_in;
   logic                 rsp_fdir_ff, rsp_fdir_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [CircTotW-1:0]  rsp_circ_ff, rsp_circ_in;
   logic [CircTotW-1:0]  rsp_active_ff, rsp_active_in;
   logic [CellTotW-1:0]  rsp_cells_ff, rsp_cells_in;

   // Table memory.
   logic                 ram_we;
   logic [IdxW-1:0]      ram_wr_addr;
   logic [EntryW-1:0]    ram_wr_data;
   logic [EntryW-1:0]    ram_rd_data;

   logic                 entry_valid;
   logic                 entry_dir;
   logic [CellW-1:0]     entry_cells;
   logic [CircW-1:0]     entry_circ;
   logic [ChanW-1:0]     entry_chan;
   logic [ChanW-1:0]     key_chan;
   logic [CircW-1:0]     key_circ;
   logic                 hit;
   logic [RemW-1:0]      rem_t;
   logic [IdxW-1:0]      rem_next;

   cft_ram #(
      .Width (EntryW),
      .Depth (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (idx_in),
      .rd_data (ram_rd_data)
   );

   assign entry_valid = ram_rd_data[EntryW-1];
   assign entry_dir   = ram_rd_data[EntryW-2];
   assign entry_cells = ram_rd_data[ChanW+CircW +: CellW];
   assign entry_circ  = ram_rd_data[ChanW +: CircW];
   assign entry_chan  = ram_rd_data[ChanW-1:0];

   assign key_chan = alt_sel_ff ? alt_chan_ff : chan_ff;
   assign key_circ = alt_sel_ff ? alt_circ_ff : circ_ff;
   assign hit      = entry_valid && (entry_chan == key_chan) && (entry_circ == key_circ);

   // The slot index is the hash modulo the table size, taken a byte per cycle by
   // restoring remainder steps, most significant bit first.
   always_comb begin
      rem_t    = '0;
      rem_next = idx_ff;
      for (int b = 0; b < HashBitsPerCycle; b++) begin
         rem_t = {rem_next, hash_ff[HashW-1-b]};
         if (rem_t >= RemW'(TABLE_ENTRIES)) begin
            rem_t = rem_t - RemW'(TABLE_ENTRIES);
         end
         rem_next = rem_t[IdxW-1:0];
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in        = state_ff;
      idx_in          = idx_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      circ_total_in   = circ_total_ff;
      active_total_in = active_total_ff;
      cell_total_in   = cell_total_ff;
      func_in         = func_ff;
      chan_in         = chan_ff;
      circ_in         = circ_ff;
      dir_in          = dir_ff;
      cells_in        = cells_ff;
      alt_valid_in    = alt_valid_ff;
      alt_chan_in     = alt_chan_ff;
      alt_circ_in     = alt_circ_ff;
      alt_sel_in      = alt_sel_ff;
      hash_in         = hash_ff;
      step_in         = step_ff;
      cnt_in          = cnt_ff;
      found_in        = found_ff;
      fdir_in         = fdir_ff;
      status_in       = status_ff;
      rsp_found_in    = rsp_found_ff;
      rsp_fdir_in     = rsp_fdir_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_circ_in     = rsp_circ_ff;
      rsp_active_in   = rsp_active_ff;
      rsp_cells_in    = rsp_cells_ff;
      ram_we          = 1'b0;
      ram_wr_addr     = idx_ff;
      ram_wr_data     = '0;

      unique case (state_ff)
         S_CLEAR: begin
            ram_we = 1'b1;
            if (idx_ff == IdxW'(TABLE_ENTRIES - 1)) begin
               idx_in   = '0;
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               func_in      = func_type'(req_func);
               chan_in      = req_chan_id;
               circ_in      = req_circ_id[CircW-1:0];
               dir_in       = req_direction;
               cells_in     = req_cell_count;
               alt_valid_in = req_alt_valid;
               alt_chan_in  = req_alt_chan_id;
               alt_circ_in  = req_alt_circ_id[CircW-1:0];
               alt_sel_in   = 1'b0;
               hash_in      = key_hash(req_chan_id, req_circ_id[CircW-1:0]);
               idx_in       = '0;
               step_in      = '0;
               state_in     = S_HASH;
            end
         end

         S_HASH: begin
            idx_in  = rem_next;
            hash_in = hash_ff << HashBitsPerCycle;
            step_in = step_ff + 1'b1;
            if (step_ff == StepW'(HashSteps - 1)) begin
               cnt_in   = '0;
               state_in = S_PROBE;
            end
         end

         S_PROBE: begin
            if (!entry_valid || hit || cnt_ff == CntW'(TABLE_ENTRIES - 1)) begin
               found_in  = 1'b0;
               fdir_in   = 1'b0;
               status_in = ST_OK;
               state_in  = S_DONE;
               if (func_ff == FUNC_ATTACH) begin
                  if (hit) begin
                     found_in = 1'b1;
                     fdir_in  = entry_dir;
                     if (entry_dir != dir_ff) begin
                        status_in = ST_MISMATCH;
                     end else begin
                        ram_we      = 1'b1;
                        ram_wr_data = {1'b1, entry_dir, cells_ff, entry_circ, entry_chan};
                        if (entry_cells != '0 && cells_ff == '0) begin
                           active_total_in = active_total_ff - 1'b1;
                        end else if (entry_cells == '0 && cells_ff != '0) begin
                           active_total_in = active_total_ff + 1'b1;
                        end
                        cell_total_in = cell_total_ff - CellTotW'(entry_cells)
                                        + CellTotW'(cells_ff);
                     end
                  end else if (!entry_valid) begin
                     ram_we          = 1'b1;
                     ram_wr_data     = {1'b1, dir_ff, cells_ff, circ_ff, chan_ff};
                     circ_total_in   = circ_total_ff + 1'b1;
                     active_total_in = active_total_ff + CircTotW'(cells_ff != '0);
                     cell_total_in   = cell_total_ff + CellTotW'(cells_ff);
                  end else begin
                     status_in = ST_FULL;
                  end
               end else begin
                  if (hit) begin
                     found_in = 1'b1;
                     fdir_in  = entry_dir;
                     // The out-side key should name an out entry, the in-side key an in entry.
                     if (entry_dir != (alt_sel_ff ? DIR_IN : DIR_OUT)) begin
                        status_in = ST_MISMATCH;
                     end
                  end else if (!alt_sel_ff && alt_valid_ff) begin
                     alt_sel_in = 1'b1;
                     hash_in    = key_hash(alt_chan_ff, alt_circ_ff);
                     idx_in     = '0;
                     step_in    = '0;
                     state_in   = S_HASH;
                  end
               end
            end else begin
               idx_in = (idx_ff == IdxW'(TABLE_ENTRIES - 1)) ? '0 : idx_ff + 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = found_ff;
               rsp_fdir_in   = fdir_ff;
               rsp_status_in = status_ff;
               rsp_circ_in   = circ_total_ff;
               rsp_active_in = active_total_ff;
               rsp_cells_in  = cell_total_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_CLEAR;
         idx_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
         circ_total_ff   <= '0;
         active_total_ff <= '0;
         cell_total_ff   <= '0;
      end else begin
         state_ff        <= state_in;
         idx_ff          <= idx_in;
         rsp_valid_ff    <= rsp_valid_in;
         circ_total_ff   <= circ_total_in;
         active_total_ff <= active_total_in;
         cell_total_ff   <= cell_total_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      chan_ff       <= chan_in;
      circ_ff       <= circ_in;
      dir_ff        <= dir_in;
      cells_ff      <= cells_in;
      alt_valid_ff  <= alt_valid_in;
      alt_chan_ff   <= alt_chan_in;
      alt_circ_ff   <= alt_circ_in;
      alt_sel_ff    <= alt_sel_in;
      hash_ff       <= hash_in;
      step_ff       <= step_in;
      cnt_ff        <= cnt_in;
      found_ff      <= found_in;
      fdir_ff       <= fdir_in;
      status_ff     <= status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_fdir_ff   <= rsp_fdir_in;
      rsp_status_ff <= rsp_status_in;
      rsp_circ_ff   <= rsp_circ_in;
      rsp_active_ff <= rsp_active_in;
      rsp_cells_ff  <= rsp_cells_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_found           = rsp_found_ff;
   assign rsp_found_direction = rsp_fdir_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_total_circuits  = rsp_circ_ff;
   assign rsp_loaded_circuits = rsp_active_ff;
   assign rsp_total_cells     = rsp_cells_ff;

   a_write_only_clear_or_probe: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_CLEAR || state_ff == S_PROBE))
      else $error("table written outside the clearing pass and the probe phase");

   a_probe_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE) |-> (cnt_ff < CntW'(TABLE_ENTRIES)))
      else $error("probe sequence ran past the table size");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result presented without a finished lookup");

   a_full_not_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_FULL) |-> !rsp_found_ff)
      else $error("table-full status reported with a hit");

   a_totals_from_probe: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(cell_total_ff)) |-> $past(state_ff == S_PROBE))
      else $error("cell total changed outside the probe phase");

endmodule

`default_nettype wire

>>> src/cft_ram.sv
`default_nettype none

module cft_ram #(
   parameter int Width = 8,
   parameter int Depth = 16,
   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [Width-1:0] wr_data,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [Width-1:0] rd_data
);

   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

>>> tb/sv/flow_table_checker.sv
`timescale 1ns / 100ps

module flow_table_checker #(
   parameter int TableEntries = cft_pkg::TableEntriesDef,
   parameter int CircIdBits   = cft_pkg::CircIdBitsDef
) (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic                            req_func,
   input  logic [cft_pkg::ChanW-1:0]       req_chan_id,
   input  logic [cft_pkg::CircInW-1:0]     req_circ_id,
   input  logic                            req_direction,
   input  logic [cft_pkg::CellW-1:0]       req_cell_count,
   input  logic                            req_alt_valid,
   input  logic [cft_pkg::ChanW-1:0]       req_alt_chan_id,
   input  logic [cft_pkg::CircInW-1:0]     req_alt_circ_id,

   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic                            rsp_found,
   input  logic                            rsp_found_direction,
   input  logic [cft_pkg::StatusW-1:0]     rsp_status,
   input  logic [cft_pkg::CircTotW-1:0]    rsp_total_circuits,
   input  logic [cft_pkg::CircTotW-1:0]    rsp_loaded_circuits,
   input  logic [cft_pkg::CellTotW-1:0]    rsp_total_cells,

   output int                              failures,
   output int                              outstanding
);

   import cft_pkg::*;

   localparam logic [HashW-1:0] CircMask =
      (CircIdBits >= HashW) ? 32'hffff_ffff : (32'd1 << CircIdBits) - 32'd1;

   typedef struct packed {
      logic                found;
      dir_type             found_dir;
      status_type          status;
      logic [CircTotW-1:0] circuits;
      logic [CircTotW-1:0] active;
      logic [CellTotW-1:0] cells;
   } outcome_type;

   bit                slot_used  [TableEntries];
   logic [ChanW-1:0]  slot_chan  [TableEntries];
   logic [HashW-1:0]  slot_circ  [TableEntries];
   logic [CellW-1:0]  slot_cells [TableEntries];
   dir_type           slot_dir   [TableEntries];
   int unsigned       circuit_count;
   int unsigned       active_count;
   int unsigned       cell_sum;

   outcome_type       awaited[$];
   outcome_type       want;

   initial failures = 0;
   initial outstanding = 0;

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      failures++;
   endtask

   // Linear probe from the home slot. A miss leaves pos on the first empty
   // slot, or at -1 when every slot was visited without meeting one.
   function automatic bit find_circuit(input logic [ChanW-1:0] chan,
                                       input logic [HashW-1:0] circ,
                                       output int pos);
      logic [HashW-1:0] home;
      int unsigned      idx;
      int               n;
      home = (circ << HashCircShift) ^ chan[63:32] ^ chan[31:0];
      idx = home % TableEntries;
      for (n = 0; n < TableEntries; n++) begin
         if (!slot_used[idx]) begin
            pos = idx;
            return 1'b0;
         end
         if (slot_chan[idx] == chan && slot_circ[idx] == circ) begin
            pos = idx;
            return 1'b1;
         end
         idx = (idx + 1) % TableEntries;
      end
      pos = -1;
      return 1'b0;
   endfunction

   // Applies the accepted transaction to the shadow table and returns the
   // result that the block owes for it.
   function automatic outcome_type track_request();
      outcome_type      res;
      int               pos;
      logic [HashW-1:0] key_circ;
      logic [HashW-1:0] alt_key_circ;
      logic [CellW-1:0] old_cells;
      res = '0;
      key_circ = {16'd0, req_circ_id} & CircMask;
      alt_key_circ = {16'd0, req_alt_circ_id} & CircMask;
      if (func_type'(req_func) == FUNC_ATTACH) begin
         if (find_circuit(req_chan_id, key_circ, pos)) begin
            res.found = 1'b1;
            res.found_dir = slot_dir[pos];
            if (slot_dir[pos] != dir_type'(req_direction)) begin
               res.status = ST_MISMATCH;
            end else begin
               old_cells = slot_cells[pos];
               if (old_cells != 0 && req_cell_count == 0) begin
                  active_count--;
               end else if (old_cells == 0 && req_cell_count != 0) begin
                  active_count++;
               end
               cell_sum = cell_sum - old_cells + req_cell_count;
               slot_cells[pos] = req_cell_count;
            end
         end else if (pos < 0) begin
            res.status = ST_FULL;
         end else begin
            slot_used[pos] = 1'b1;
            slot_chan[pos] = req_chan_id;
            slot_circ[pos] = key_circ;
            slot_cells[pos] = req_cell_count;
            slot_dir[pos] = dir_type'(req_direction);
            circuit_count++;
            if (req_cell_count != 0) begin
               active_count++;
            end
            cell_sum += req_cell_count;
         end
      end else begin
         if (find_circuit(req_chan_id, key_circ, pos)) begin
            res.found = 1'b1;
            res.found_dir = slot_dir[pos];
            if (slot_dir[pos] != DIR_OUT) begin
               res.status = ST_MISMATCH;
            end
         end else if (req_alt_valid && find_circuit(req_alt_chan_id, alt_key_circ, pos)) begin
            res.found = 1'b1;
            res.found_dir = slot_dir[pos];
            if (slot_dir[pos] != DIR_IN) begin
               res.status = ST_MISMATCH;
            end
         end
      end
      res.circuits = circuit_count[CircTotW-1:0];
      res.active = active_count[CircTotW-1:0];
      res.cells = cell_sum[CellTotW-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TableEntries; i++) begin
            slot_used[i] = 1'b0;
         end
         circuit_count = 0;
         active_count = 0;
         cell_sum = 0;
         awaited.delete();
         outstanding <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited.size() == 0) begin
               report_mismatch($sformatf("result with no transaction outstanding: found %0b status %0d",
                                         rsp_found, rsp_status));
            end else begin
               want = awaited.pop_front();
               if (rsp_found !== want.found)
                  report_mismatch($sformatf("found: got %0b, expected %0b",
                                            rsp_found, want.found));
               if (rsp_found_direction !== want.found_dir)
                  report_mismatch($sformatf("found_direction: got %0b, expected %0b",
                                            rsp_found_direction, want.found_dir));
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status: got %0d, expected %0d",
                                            rsp_status, want.status));
               if (rsp_total_circuits !== want.circuits)
                  report_mismatch($sformatf("total_circuits: got %0d, expected %0d",
                                            rsp_total_circuits, want.circuits));
               if (rsp_loaded_circuits !== want.active)
                  report_mismatch($sformatf("loaded_circuits: got %0d, expected %0d",
                                            rsp_loaded_circuits, want.active));
               if (rsp_total_cells !== want.cells)
                  report_mismatch($sformatf("total_cells: got %0d, expected %0d",
                                            rsp_total_cells, want.cells));
            end
         end
         if (req_valid && !req_stall) begin
            awaited.push_back(track_request());
         end
         outstanding <= awaited.size();
      end
   end

endmodule

>>> tb/sv/circuit_flow_table_with_counters_test.sv
`timescale 1ns / 100ps

module circuit_flow_table_with_counters_test;

   import cft_pkg::*;

   localparam realtime ClockPeriod = 8ns;
   localparam int ResetCycles  = 9;
   localparam int RandomItems  = 600;
   localparam int PoolSize     = 96;
   localparam int BaseChans    = 12;
   localparam int HoldAt       = 150;
   localparam int PauseAt      = 320;
   localparam int HoldCycles   = 400;
   // A query that misses on both keys in a full table probes every slot twice.
   localparam int SettleCycles = 200;
   localparam int CycleLimit   = 600000;

   typedef struct packed {
      func_type          func;
      logic [ChanW-1:0]  chan;
      logic [CircInW-1:0] circ;
      dir_type           dir;
      logic [CellW-1:0]  cells;
      logic              alt_valid;
      logic [ChanW-1:0]  alt_chan;
      logic [CircInW-1:0] alt_circ;
   } req_item_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;

   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_func = 1'b0;
   logic [ChanW-1:0]    req_chan_id = '0;
   logic [CircInW-1:0]  req_circ_id = '0;
   logic                req_direction = 1'b0;
   logic [CellW-1:0]    req_cell_count = '0;
   logic                req_alt_valid = 1'b0;
   logic [ChanW-1:0]    req_alt_chan_id = '0;
   logic [CircInW-1:0]  req_alt_circ_id = '0;

   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_found;
   logic                rsp_found_direction;
   logic [StatusW-1:0]  rsp_status;
   logic [CircTotW-1:0] rsp_total_circuits;
   logic [CircTotW-1:0] rsp_loaded_circuits;
   logic [CellTotW-1:0] rsp_total_cells;

   int                  mismatch_count;
   int                  outstanding;
   int                  cycle_count;
   int                  burst_left = 0;
   bit                  hold_request = 1'b0;

   logic [ChanW-1:0]    pool_chan [PoolSize];
   logic [CircInW-1:0]  pool_circ [PoolSize];
   dir_type             pool_dir  [PoolSize];
   logic [ChanW-1:0]    base_chan [BaseChans];

   always #(ClockPeriod / 2) clock = ~clock;

   circuit_flow_table_with_counters dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_func            (req_func),
      .req_chan_id         (req_chan_id),
      .req_circ_id         (req_circ_id),
      .req_direction       (req_direction),
      .req_cell_count      (req_cell_count),
      .req_alt_valid       (req_alt_valid),
      .req_alt_chan_id     (req_alt_chan_id),
      .req_alt_circ_id     (req_alt_circ_id),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_found           (rsp_found),
      .rsp_found_direction (rsp_found_direction),
      .rsp_status          (rsp_status),
      .rsp_total_circuits  (rsp_total_circuits),
      .rsp_loaded_circuits (rsp_loaded_circuits),
      .rsp_total_cells     (rsp_total_cells)
   );

   flow_table_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_func            (req_func),
      .req_chan_id         (req_chan_id),
      .req_circ_id         (req_circ_id),
      .req_direction       (req_direction),
      .req_cell_count      (req_cell_count),
      .req_alt_valid       (req_alt_valid),
      .req_alt_chan_id     (req_alt_chan_id),
      .req_alt_circ_id     (req_alt_circ_id),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_found           (rsp_found),
      .rsp_found_direction (rsp_found_direction),
      .rsp_status          (rsp_status),
      .rsp_total_circuits  (rsp_total_circuits),
      .rsp_loaded_circuits (rsp_loaded_circuits),
      .rsp_total_cells     (rsp_total_cells),
      .failures            (mismatch_count),
      .outstanding         (outstanding)
   );

   function automatic req_item_type make_item(input func_type func, input logic [ChanW-1:0] chan,
                                              input logic [CircInW-1:0] circ, input dir_type dir,
                                              input logic [CellW-1:0] cells, input logic alt_valid,
                                              input logic [ChanW-1:0] alt_chan,
                                              input logic [CircInW-1:0] alt_circ);
      req_item_type it;
      it.func = func;
      it.chan = chan;
      it.circ = circ;
      it.dir = dir;
      it.cells = cells;
      it.alt_valid = alt_valid;
      it.alt_chan = alt_chan;
      it.alt_circ = alt_circ;
      return it;
   endfunction

   // Mostly attaches and queries on a pool of keys that outnumbers the table slots,
   // so that the table fills and probe chains grow long; the rest is noise.
   function automatic req_item_type random_item();
      req_item_type it;
      int unsigned  pick;
      int unsigned  k;
      int unsigned  j;
      pick = $urandom_range(0, 99);
      k = $urandom_range(0, PoolSize - 1);
      j = $urandom_range(0, PoolSize - 1);
      it = make_item(FUNC_QUERY, {$urandom, $urandom}, 16'($urandom_range(0, 16'hffff)),
                     dir_type'($urandom_range(0, 1)), 16'($urandom_range(0, 16'hffff)),
                     1'($urandom_range(0, 1)), {$urandom, $urandom},
                     16'($urandom_range(0, 16'hffff)));
      if (pick < 50) begin
         it.func = FUNC_ATTACH;
         it.chan = pool_chan[k];
         it.circ = pool_circ[k];
         it.dir = ($urandom_range(0, 9) == 0) ? dir_type'(~pool_dir[k]) : pool_dir[k];
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            it.cells = '0;
         end else if (pick < 30) begin
            it.cells = '1;
         end
      end else if (pick < 90) begin
         if ($urandom_range(0, 3) != 0) begin
            it.chan = pool_chan[k];
            it.circ = pool_circ[k];
         end
         if ($urandom_range(0, 2) != 0) begin
            it.alt_chan = pool_chan[j];
            it.alt_circ = pool_circ[j];
         end
      end else begin
         it.func = func_type'($urandom_range(0, 1));
      end
      return it;
   endfunction

   // Offers one transaction and returns at the edge where it is taken.
   // Bursts of random length are separated by random gaps.
   task automatic send_item(input req_item_type it);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 :
               $urandom_range(1, ($urandom_range(0, 7) == 0) ? 40 : 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_func <= it.func;
      req_chan_id <= it.chan;
      req_circ_id <= it.circ;
      req_direction <= it.dir;
      req_cell_count <= it.cells;
      req_alt_valid <= it.alt_valid;
      req_alt_chan_id <= it.alt_chan;
      req_alt_circ_id <= it.alt_circ;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   initial begin : receiver
      int unsigned hold_left;
      int unsigned stretch_left;
      int unsigned stall_pct;
      hold_left = 0;
      stretch_left = 0;
      stall_pct = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HoldCycles;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (stretch_left == 0) begin
               stretch_left = $urandom_range(8, 60);
               stall_pct = 30 * $urandom_range(0, 3);
            end
            stretch_left--;
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   initial begin : stimulus
      int n;
      for (n = 0; n < BaseChans; n++) begin
         base_chan[n] = {$urandom, $urandom};
      end
      for (n = 0; n < PoolSize; n++) begin
         if (n == 0) begin
            pool_chan[n] = '0;
         end else if (n == 1) begin
            pool_chan[n] = '1;
         end else if (n % 2 == 0) begin
            pool_chan[n] = base_chan[$urandom_range(0, BaseChans - 1)];
         end else begin
            pool_chan[n] = {$urandom, $urandom};
         end
         if (n % 7 == 0) begin
            pool_circ[n] = '1;
         end else if (n % 11 == 0) begin
            pool_circ[n] = '0;
         end else begin
            pool_circ[n] = 16'($urandom_range(0, 16'hffff));
         end
         pool_dir[n] = dir_type'($urandom_range(0, 1));
      end

      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      // Keys whose channel halves cancel all share home slot zero with the
      // all-zero key, which builds a probe chain from the outset.
      send_item(make_item(FUNC_QUERY, '1, '1, DIR_IN, '1, 1'b1, '1, '1));
      send_item(make_item(FUNC_ATTACH, '0, '0, DIR_OUT, '0, 1'b1, '1, '1));
      send_item(make_item(FUNC_ATTACH, '1, '1, DIR_IN, '1, 1'b0, '0, '0));
      send_item(make_item(FUNC_ATTACH, '0, '0, DIR_OUT, 16'd5, 1'b0, '0, '0));
      send_item(make_item(FUNC_ATTACH, '1, '1, DIR_IN, '0, 1'b1, '0, '0));
      send_item(make_item(FUNC_ATTACH, '0, '0, DIR_IN, 16'd7, 1'b0, '0, '0));
      send_item(make_item(FUNC_ATTACH, '1, '1, DIR_OUT, 16'd1, 1'b0, '0, '0));
      send_item(make_item(FUNC_QUERY, '0, '0, DIR_IN, '1, 1'b0, '0, '0));
      send_item(make_item(FUNC_QUERY, '1, '1, DIR_OUT, '0, 1'b1, '0, '0));
      send_item(make_item(FUNC_QUERY, 64'd5, '0, DIR_OUT, '0, 1'b1, '1, '1));
      send_item(make_item(FUNC_QUERY, 64'd5, '0, DIR_OUT, '0, 1'b1, '0, '0));
      send_item(make_item(FUNC_QUERY, 64'd5, '0, DIR_OUT, '0, 1'b0, '1, '1));
      send_item(make_item(FUNC_ATTACH, 64'h0000_0001_0000_0001, 16'h1234, DIR_OUT, '1,
                          1'b0, '0, '0));
      send_item(make_item(FUNC_ATTACH, '0, 16'd1, DIR_IN, 16'd3, 1'b0, '0, '0));
      send_item(make_item(FUNC_QUERY, '0, 16'd1, DIR_OUT, '0, 1'b0, '0, '0));
      send_item(make_item(FUNC_QUERY, 64'h0000_0001_0000_0001, 16'h1234, DIR_OUT, '0,
                          1'b1, '0, '0));
      send_item(make_item(FUNC_ATTACH, '0, 16'd1, DIR_IN, '1, 1'b0, '0, '0));
      send_item(make_item(FUNC_QUERY, '0, '1, DIR_OUT, '0, 1'b1, '0, 16'h0002));
      send_item(make_item(FUNC_ATTACH, 64'haaaa_aaaa_5555_5555, 16'haaaa, DIR_IN, 16'h8000,
                          1'b1, 64'h5555_5555_aaaa_aaaa, 16'h5555));
      send_item(make_item(FUNC_QUERY, 64'h5555_5555_aaaa_aaaa, 16'h5555, DIR_IN, 16'h7fff,
                          1'b1, 64'haaaa_aaaa_5555_5555, 16'haaaa));

      for (n = 0; n < RandomItems; n++) begin
         if (n == HoldAt) begin
            hold_request = 1'b1;
         end
         if (n == PauseAt) begin
            wait_for_results();
         end
         send_item(random_item());
      end

      wait_for_results();
      repeat (SettleCycles) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
